// ----- hw/rtl/first_fit_heap_allocator_defines.svh -----
// Assertion macros used by the allocator controller (ffha_ctrl).
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ffha_pkg.sv -----
// Types and constants of the first-fit heap allocator.
package ffha_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 16;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W       = 21;
   localparam int START_W      = 20;
   localparam logic [ADDR_W-1:0] HEAP_SPAN = ADDR_W'(1048576);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NULL    = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_FINISH
   } ctrl_state_type;

   // Search transaction walking the cell chain.
   typedef struct packed {
      logic               valid;
      logic               active;   // cleared for zero-size alloc / null free
      cmd_type            cmd;
      logic [ADDR_W-1:0]  size;
      logic [ADDR_W-1:0]  addr;
      logic               found;
      logic               top_hit;  // hit block is the last table entry
      logic [START_W-1:0] start;
   } token_type;

   // Append write broadcast to the cells.
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [START_W-1:0] start;
      logic [ADDR_W-1:0]  size;
   } wr_type;

endpackage

// ----- hw/rtl/ffha_cell.sv -----
// One block-table entry plus one stage of the search chain.
module ffha_cell
   import ffha_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic [CNT_W-1:0] entry_count,
   input  wr_type           wr,
   input  token_type        tok_in,
   output token_type        tok_out
);

   logic [START_W-1:0] start_ff;
   logic [ADDR_W-1:0]  size_ff;
   logic               free_ff;
   token_type          tok_ff, tok_in_w;

   logic [CNT_W-1:0] idx_ext;
   logic             in_use, is_last, hit_alloc, hit_free, hit, wr_hit;

   always_comb begin
      idx_ext   = CNT_W'(cell_idx);
      in_use    = idx_ext < entry_count;
      is_last   = (idx_ext + CNT_W'(1)) == entry_count;
      hit_alloc = (tok_in.cmd == CMD_ALLOC) && free_ff && (size_ff >= tok_in.size);
      hit_free  = (tok_in.cmd == CMD_FREE) &&
                  ((ADDR_W'(start_ff) + ADDR_W'(HEADER_BYTES)) == tok_in.addr);
      hit       = tok_in.valid && tok_in.active && !tok_in.found && in_use &&
                  (hit_alloc || hit_free);
      wr_hit    = wr.en && (wr.idx == cell_idx);

      tok_in_w = tok_in;
      if (hit) begin
         tok_in_w.found   = 1'b1;
         tok_in_w.top_hit = is_last;
         tok_in_w.start   = start_ff;
      end
   end

   // entry storage: no reset, only entries below entry_count are looked at
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         start_ff <= wr.start;
         size_ff  <= wr.size;
         free_ff  <= 1'b0;
      end else if (hit) begin
         free_ff <= (tok_in.cmd == CMD_FREE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- hw/rtl/ffha_ctrl.sv -----
// Controller: handshakes, heap top, entry count, append and result register.
`include "first_fit_heap_allocator_defines.svh"
module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_payload_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [1:0]        rsp_status,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data,
   output token_type         launch,
   input  token_type         chain_out,
   output logic [CNT_W-1:0]  entry_count,
   output wr_type            wr
);

   ctrl_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [ADDR_W-1:0] heap_top_ff, heap_top_in;
   logic [ADDR_W-1:0] heap_limit_ff;
   token_type         fin_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              accept, slot_free, fire, fits;
   logic [ADDR_W-1:0] lim;
   logic [ADDR_W:0]   end_sum;

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == S_FINISH) && slot_free;

   always_comb begin
      launch.valid   = accept;
      launch.cmd     = cmd_type'(req_command);
      launch.size    = req_request_size;
      launch.addr    = req_payload_address;
      launch.active  = (cmd_type'(req_command) == CMD_ALLOC) ? (req_request_size != '0)
                                                              : (req_payload_address != '0);
      launch.found   = 1'b0;
      launch.top_hit = 1'b0;
      launch.start   = '0;
   end

   always_comb begin
      lim     = (heap_limit_ff > HEAP_SPAN) ? HEAP_SPAN : heap_limit_ff;
      end_sum = {1'b0, heap_top_ff} + (ADDR_W + 1)'(HEADER_BYTES) + {1'b0, fin_ff.size};
      fits    = (entry_count_ff < CNT_W'(MAX_BLOCKS)) && (end_sum <= {1'b0, lim});
   end

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      heap_top_in    = heap_top_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;
      wr.en          = 1'b0;
      wr.idx         = entry_count_ff[IDX_W-1:0];
      wr.start       = heap_top_ff[START_W-1:0];
      wr.size        = fin_ff.size;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (chain_out.valid) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (fire) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_OK;
               priority if (!fin_ff.active) begin
                  rsp_status_in = ST_NULL;
               end else if (fin_ff.cmd == CMD_ALLOC) begin
                  priority if (fin_ff.found) begin
                     rsp_addr_in = ADDR_W'(fin_ff.start) + ADDR_W'(HEADER_BYTES);
                  end else if (fits) begin
                     // append a new block at the heap top
                     wr.en          = 1'b1;
                     entry_count_in = entry_count_ff + CNT_W'(1);
                     heap_top_in    = end_sum[ADDR_W-1:0];
                     rsp_addr_in    = heap_top_ff + ADDR_W'(HEADER_BYTES);
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end else begin
                  priority if (fin_ff.found && fin_ff.top_hit) begin
                     // top block freed: heap shrinks, entry dropped
                     heap_top_in    = ADDR_W'(fin_ff.start);
                     entry_count_in = entry_count_ff - CNT_W'(1);
                  end else if (!fin_ff.found) begin
                     rsp_status_in = ST_UNKNOWN;
                  end else begin
                     rsp_status_in = ST_OK;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         heap_top_ff    <= '0;
         heap_limit_ff  <= HEAP_SPAN;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         heap_top_ff    <= heap_top_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            heap_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      if (state_ff == S_SEARCH && chain_out.valid) begin
         fin_ff <= chain_out;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign entry_count        = entry_count_ff;

   `FFHA_ASSERT_NOW(a_count_bound, 1'b1, entry_count_ff <= CNT_W'(MAX_BLOCKS), "count overflow")
   `FFHA_ASSERT_NOW(a_chain_in_search, chain_out.valid, state_ff == S_SEARCH, "stray result")
   `FFHA_ASSERT_NOW(a_top_bound, 1'b1, heap_top_ff <= HEAP_SPAN, "heap top beyond span")
   `FFHA_ASSERT_NOW(a_empty_top, entry_count_ff == '0, heap_top_ff == '0, "top nonzero")
   `FFHA_ASSERT_NEXT(a_accept_search, accept, state_ff == S_SEARCH, "accept not searching")

endmodule

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: controller plus chain of table cells.
//
// Usage
//   req_*  : allocate (command 0, request_size) or free (command 1, payload_address).
//            A transaction is taken when req_valid is high and req_stall low.
//   rsp_*  : one result per request: result_address and status
//            (0 ok, 1 zero size / null, 2 heap or table full, 3 unknown address).
//   csr_*  : csr_wr_en writes heap_limit from csr_wr_data; write only while idle.
// Timing
//   Every request walks the full row of MAX_BLOCKS cells, one cell per cycle,
//   then is captured from the chain end into the controller, whose finish step
//   waits for a free result slot and registers the result. One request is in
//   flight at a time; the next is taken in the same cycle as the result is
//   raised, so no new request is taken before the last one's result is out.
// Reset
//   Synchronous, active high: empty table, heap top 0, heap_limit 1048576.
//   Table entries are not cleared; only entries below the count are read.
// Stalls
//   The result waits in its output register while rsp_stall is high; a new
//   request is still taken and searched, and finishes once the slot drains.
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_payload_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [1:0]        rsp_status,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data
);

   // tok[i] feeds cell i; tok[MAX_BLOCKS] returns to the controller
   token_type        tok [0:MAX_BLOCKS];
   logic [CNT_W-1:0] entry_count;
   wr_type           wr;

   ffha_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_request_size    (req_request_size),
      .req_payload_address (req_payload_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_address  (rsp_result_address),
      .rsp_status          (rsp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .launch              (tok[0]),
      .chain_out           (tok[MAX_BLOCKS]),
      .entry_count         (entry_count),
      .wr                  (wr)
   );

   // cell i owns table entry i; the search transaction moves one cell per cycle
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      ffha_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .entry_count (entry_count),
         .wr          (wr),
         .tok_in      (tok[i]),
         .tok_out     (tok[i+1])
      );
   end

endmodule
